### rtl/rgrw_pkg.sv
package rgrw_pkg;

  // samples summed into one approximate normal value
  localparam int unsigned SamplesPerNormal = 12;

  localparam int SAMPLE_W  = 16;
  localparam int SUM_W     = 23;
  localparam int CNT_W     = 7;
  localparam int WALK_W    = 17;
  localparam int OFFS_W    = 24;
  localparam int NOISE_W   = 16;
  localparam int GAIN_W    = 18;
  localparam int SCALE_W   = GAIN_W + NOISE_W;
  localparam int CENT_W    = SUM_W + 1;
  localparam int MAG_W     = SUM_W;
  localparam int PROD_W    = MAG_W + SCALE_W;
  localparam int RND_SHIFT = 28;
  localparam int OMAG_W    = PROD_W + 1 - RND_SHIFT;
  localparam int NEXT_W    = OFFS_W + 2;
  localparam int TDATA_W   = 48;

  // integer square root, evaluated at elaboration only
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bitv;
    rem  = v;
    res  = 64'd0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // sqrt(12/N) in unsigned Q2.16, rounded to nearest
  localparam logic [63:0] GainRaw =
    (isqrt64((64'd12 << 34) / 64'(SamplesPerNormal)) + 64'd1) >> 1;
  localparam logic [GAIN_W-1:0] NORM_GAIN = GainRaw[GAIN_W-1:0];

  localparam logic [NOISE_W-1:0] NOISE_RESET = 16'd4096;
  localparam logic [63:0] ScaleResetRaw = GainRaw * 64'(NOISE_RESET);
  localparam logic [SCALE_W-1:0] SCALE_RESET = ScaleResetRaw[SCALE_W-1:0];

  localparam logic [63:0] CenterRaw = 64'(SamplesPerNormal) * 64'd32768;
  localparam logic [CENT_W-1:0] SUM_CENTER = CenterRaw[CENT_W-1:0];

  localparam logic [CNT_W-1:0]  GROUP_LAST = CNT_W'(SamplesPerNormal);
  localparam logic [WALK_W-1:0] WALK_ONE   = 17'd65536;
  localparam logic [WALK_W-1:0] WALK_HALF  = 17'd32768;

  localparam logic [OMAG_W-1:0] OMAG_NEG_MAX = OMAG_W'(24'h800000);
  localparam logic [OMAG_W-1:0] OMAG_POS_MAX = OMAG_W'(24'h7fffff);

endpackage

### rtl/reflected_gaussian_random_walk_top.sv
// latency: the word that completes a group of samples shows its result on the next cycle
// throughput: one sample word per cycle while s_tready is high, one result per group of samples
// the sum, scale multiply, round, clamp and reflection run in one pass into m_tdata
// s_tready drops only while an untaken result holds the output register
// synchronous reset: walk at one half, sum and count cleared, noise scale 1.0, no result
module reflected_gaussian_random_walk_top (
  input  logic                           clk,
  input  logic                           rst,
  // config register noise_scale, unsigned Q4.12
  input  logic                           cfg_we,
  input  logic [rgrw_pkg::NOISE_W-1:0]   cfg_data,
  // sample stream, tdata: uniform_sample [15:0]
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [rgrw_pkg::SAMPLE_W-1:0]  s_tdata,
  // result stream, tdata: walk_value [16:0], step_offset [40:17], zero pad [47:41]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [rgrw_pkg::TDATA_W-1:0]   m_tdata
);

  // state
  logic [rgrw_pkg::SUM_W-1:0]   sample_sum;
  logic [rgrw_pkg::CNT_W-1:0]   sample_count;
  logic [rgrw_pkg::WALK_W-1:0]  current_walk;
  // gain times noise_scale, folded at config time
  logic [rgrw_pkg::SCALE_W-1:0] scale;

  // single pass datapath
  logic                                sample_take;
  logic [rgrw_pkg::SUM_W-1:0]          sample_sum_next;
  logic [rgrw_pkg::CNT_W-1:0]          sample_count_next;
  logic                                group_done;
  logic signed [rgrw_pkg::CENT_W-1:0]  centered;
  logic                                neg;
  logic [rgrw_pkg::CENT_W-1:0]         mag_full;
  logic [rgrw_pkg::MAG_W-1:0]          mag;
  logic [rgrw_pkg::PROD_W-1:0]         prod;
  logic [rgrw_pkg::PROD_W:0]           prod_rnd;
  logic [rgrw_pkg::OMAG_W-1:0]         omag;
  logic [rgrw_pkg::OMAG_W-1:0]         omag_sat;
  logic [rgrw_pkg::OFFS_W-1:0]         offset;
  logic signed [rgrw_pkg::NEXT_W-1:0]  walk_sum;
  logic [rgrw_pkg::NEXT_W-1:0]         walk_neg;
  logic [rgrw_pkg::WALK_W-1:0]         current_walk_next;

  // the output register frees up in the same cycle it is taken
  assign s_tready    = !m_tvalid || m_tready;
  assign sample_take = s_tvalid && s_tready;

  always_comb begin
    sample_sum_next   = sample_sum + rgrw_pkg::SUM_W'(s_tdata);
    sample_count_next = sample_count + rgrw_pkg::CNT_W'(1);
    group_done        = (sample_count_next == rgrw_pkg::GROUP_LAST);

    // center on N/2 and split into sign and magnitude
    centered = $signed({1'b0, sample_sum_next}) - $signed(rgrw_pkg::SUM_CENTER);
    neg      = centered[rgrw_pkg::CENT_W-1];
    mag_full = neg ? rgrw_pkg::CENT_W'(-centered) : rgrw_pkg::CENT_W'(centered);
    mag      = mag_full[rgrw_pkg::MAG_W-1:0];

    // one multiply, then round half away from zero on the magnitude
    prod     = rgrw_pkg::PROD_W'(mag) * rgrw_pkg::PROD_W'(scale);
    prod_rnd = {1'b0, prod}
             + ((rgrw_pkg::PROD_W + 1)'(1) << (rgrw_pkg::RND_SHIFT - 1));
    omag     = prod_rnd[rgrw_pkg::PROD_W:rgrw_pkg::RND_SHIFT];

    // clamp to the signed 24-bit offset range
    if (neg) begin
      omag_sat = (omag > rgrw_pkg::OMAG_NEG_MAX) ? rgrw_pkg::OMAG_NEG_MAX : omag;
      offset   = rgrw_pkg::OFFS_W'(-omag_sat);
    end else begin
      omag_sat = (omag > rgrw_pkg::OMAG_POS_MAX) ? rgrw_pkg::OMAG_POS_MAX : omag;
      offset   = omag_sat[rgrw_pkg::OFFS_W-1:0];
    end

    // step the walk and fold an overshoot back into [0,1] once
    walk_sum = $signed({{(rgrw_pkg::NEXT_W - rgrw_pkg::WALK_W){1'b0}}, current_walk})
             + $signed({{(rgrw_pkg::NEXT_W - rgrw_pkg::OFFS_W){offset[rgrw_pkg::OFFS_W-1]}},
                        offset});
    walk_neg = rgrw_pkg::NEXT_W'(-walk_sum);
    if (walk_sum > $signed(rgrw_pkg::NEXT_W'(rgrw_pkg::WALK_ONE))) begin
      // above one: one minus the fractional part
      current_walk_next = rgrw_pkg::WALK_ONE - {1'b0, walk_sum[15:0]};
    end else if (walk_sum[rgrw_pkg::NEXT_W-1]) begin
      // below zero: fractional part of the negated value
      current_walk_next = {1'b0, walk_neg[15:0]};
    end else begin
      current_walk_next = walk_sum[rgrw_pkg::WALK_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum   <= '0;
      sample_count <= '0;
      current_walk <= rgrw_pkg::WALK_HALF;
      scale        <= rgrw_pkg::SCALE_RESET;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        scale <= rgrw_pkg::SCALE_W'(rgrw_pkg::NORM_GAIN) * rgrw_pkg::SCALE_W'(cfg_data);
      end
      // a new result replaces one taken in the same cycle
      if (sample_take && group_done) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (sample_take) begin
        if (group_done) begin
          // group complete: emit the result word and start a new group
          sample_sum   <= '0;
          sample_count <= '0;
          current_walk <= current_walk_next;
        end else begin
          sample_sum   <= sample_sum_next;
          sample_count <= sample_count_next;
        end
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (sample_take && group_done) begin
      m_tdata <= {{(rgrw_pkg::TDATA_W - rgrw_pkg::WALK_W - rgrw_pkg::OFFS_W){1'b0}},
                  offset, current_walk_next};
    end
  end

  // a word that closes a group always produces a result next cycle
  a_group_emits: assert property (@(posedge clk) disable iff (rst)
    sample_take && group_done |=> m_tvalid)
    else $error("completed group gave no result word");

  // the pending result carries the walk value now held in state
  a_walk_matches: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[rgrw_pkg::WALK_W-1:0] == current_walk))
    else $error("result walk value differs from stored walk");

  // the walk never leaves [0,1]
  a_walk_range: assert property (@(posedge clk) disable iff (rst)
    current_walk <= rgrw_pkg::WALK_ONE)
    else $error("walk value above one");

  // an empty group has an empty sum
  a_empty_group: assert property (@(posedge clk) disable iff (rst)
    (sample_count == '0) |-> (sample_sum == '0))
    else $error("sample sum not cleared with count");

endmodule

### bench/tb.sv
`timescale 1ns / 100ps

module tb;

  // result word shows up in the cycle after the word that closes a group
  localparam int RESULT_LATENCY = 1;
  // cycles without any accepted word before the run is declared hung
  localparam int HANG_LIMIT = 4000;
  localparam int RANDOM_WORDS = 800;

  // one expected result word
  typedef struct packed {
    logic [rgrw_pkg::WALK_W-1:0] walk;
    logic [rgrw_pkg::OFFS_W-1:0] offset;
  } walk_step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [rgrw_pkg::NOISE_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [rgrw_pkg::SAMPLE_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [rgrw_pkg::TDATA_W-1:0] m_tdata;

  // expected results in order, oldest at the front
  walk_step_t walk_steps[$];

  // model state of the block
  logic [rgrw_pkg::SUM_W-1:0] model_sum = '0;
  logic [rgrw_pkg::CNT_W-1:0] model_count = '0;
  logic [rgrw_pkg::WALK_W-1:0] model_walk = rgrw_pkg::WALK_HALF;
  logic [rgrw_pkg::NOISE_W-1:0] model_noise = rgrw_pkg::NOISE_RESET;
  logic [63:0] gain_q16 = '0;

  int error_count = 0;
  int idle_cycles = 0;
  // when set, neither side inserts gaps
  logic steady = 1'b0;

  reflected_gaussian_random_walk_top dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // uniform_sample [15:0]
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)    // walk_value [16:0], step_offset [40:17], pad [47:41]
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // bitwise floor square root
  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    error_count++;
  endtask

  // fold one sample into the model, queue a result when the group closes
  task automatic advance_walk(input logic [rgrw_pkg::SAMPLE_W-1:0] sample);
    longint centered;
    longint offs;
    longint nxt;
    logic [63:0] mag;
    logic [63:0] prod;
    logic [63:0] omag;
    logic neg;
    walk_step_t step;
    model_sum = model_sum + rgrw_pkg::SUM_W'(sample);
    model_count = model_count + 1'b1;
    if (model_count < rgrw_pkg::CNT_W'(rgrw_pkg::SamplesPerNormal)) return;

    // irwin-hall: center the sum, then one multiply by gain times deviation
    centered = longint'(model_sum) - longint'(rgrw_pkg::SamplesPerNormal) * 32768;
    neg = centered < 0;
    mag = neg ? 64'(-centered) : 64'(centered);
    prod = mag * (gain_q16 * 64'(model_noise));
    // round the magnitude to nearest, ties away from zero
    omag = (prod + (64'd1 << 27)) >> 28;
    if (neg) begin
      if (omag > 64'd8388608) omag = 64'd8388608;
      offs = -longint'(omag);
    end else begin
      if (omag > 64'd8388607) omag = 64'd8388607;
      offs = longint'(omag);
    end

    // reflect at the walls, a large overshoot folds only once
    nxt = longint'(model_walk) + offs;
    if (nxt > 65536) nxt = 65536 - (nxt & 64'hffff);
    else if (nxt < 0) nxt = (-nxt) & 64'hffff;

    model_walk = rgrw_pkg::WALK_W'(nxt);
    model_sum = '0;
    model_count = '0;
    step.walk = model_walk;
    step.offset = rgrw_pkg::OFFS_W'(offs);
    walk_steps = {walk_steps, step};
  endtask

  // check result words first, then feed the accepted sample to the model
  always @(posedge clk) begin : monitor
    walk_step_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (walk_steps.size() == 0) begin
          report($sformatf("unexpected result word %h", m_tdata));
        end else begin
          want = walk_steps.pop_front();
          if (m_tdata[16:0] !== want.walk)
            report($sformatf("walk_value %0d, want %0d", m_tdata[16:0], want.walk));
          if (m_tdata[40:17] !== want.offset)
            report($sformatf("step_offset %0d, want %0d",
                             $signed(m_tdata[40:17]), $signed(want.offset)));
        end
      end
      if (s_tvalid && s_tready) advance_walk(s_tdata);
    end
  end

  // hang detection on both streams
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= HANG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // result side: random stall per word, none while steady
  initial begin : sink
    int gap;
    wait (!rst);
    @(posedge clk);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  // send one sample word, valid stays high afterward unless a gap follows
  task automatic send_sample(input logic [rgrw_pkg::SAMPLE_W-1:0] sample);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= sample;
    do @(posedge clk); while (!(s_tvalid && s_tready));
  endtask

  // stop sending and wait until every expected word has come out
  task automatic settle();
    s_tvalid <= 1'b0;
    while (walk_steps.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_noise(input logic [rgrw_pkg::NOISE_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_noise = value;
  endtask

  // mostly full range, some near the center, some at the extremes
  function automatic logic [rgrw_pkg::SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      6, 7: pick_sample = rgrw_pkg::SAMPLE_W'(32768 + $urandom_range(0, 2047) - 1024);
      8: pick_sample = '0;
      9: pick_sample = '1;
      default: pick_sample = rgrw_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  // from one half, a step of exactly +1.5 lands on 2.0 and folds back to 1.0
  task automatic test_fold_at_two();
    settle();
    repeat (rgrw_pkg::SamplesPerNormal) send_sample(16'd40960);
  endtask

  // all-zero group: deepest negative step, reflected from below zero
  task automatic test_deep_undershoot();
    repeat (rgrw_pkg::SamplesPerNormal) send_sample(16'd0);
    settle();
  endtask

  // phases of random words, each under its own deviation setting
  task automatic test_random_walk(input int count);
    int sent;
    int phase;
    int span;
    logic [rgrw_pkg::NOISE_W-1:0] noise;
    sent = 0;
    phase = 0;
    while (sent < count) begin
      case (phase)
        0: noise = '1;
        1: noise = '0;
        2: noise = 16'd1;
        default: begin
          case ($urandom_range(0, 5))
            0: noise = '0;
            1: noise = '1;
            2: noise = rgrw_pkg::NOISE_RESET;
            3: noise = rgrw_pkg::NOISE_W'($urandom_range(1, 255));
            default: noise = rgrw_pkg::NOISE_W'($urandom);
          endcase
        end
      endcase
      settle();
      write_noise(noise);
      steady = ($urandom_range(0, 3) == 0);
      span = $urandom_range(30, 150);
      for (int i = 0; i < span && sent < count; i++) begin
        send_sample(pick_sample());
        sent++;
      end
      steady = 1'b0;
      phase++;
    end
    settle();
  endtask

  initial begin
    gain_q16 = (floor_sqrt((64'd12 << 34) / 64'(rgrw_pkg::SamplesPerNormal)) + 64'd1) >> 1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_fold_at_two();
    test_deep_undershoot();
    test_random_walk(RANDOM_WORDS);

    repeat (RESULT_LATENCY + 4) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
